>>> hdl/hti_pkg.sv
package hti_pkg;

    localparam int PAGE_DEPTH = 256;
    localparam int PAGE_AW    = 8;
    localparam int CNT_W      = 14;

    // request codes
    typedef enum logic [2:0] {
        REQ_READ    = 3'd0,
        REQ_WRITE   = 3'd1,
        REQ_TICK    = 3'd2,
        REQ_STEP    = 3'd3,
        REQ_ME_ON   = 3'd4,
        REQ_ME_OFF  = 3'd5,
        REQ_CHECK   = 3'd6
    } t_req_type;

    // page offsets
    localparam logic [7:0] OFS_JOYPAD = 8'h00;
    localparam logic [7:0] OFS_SC     = 8'h02;
    localparam logic [7:0] OFS_DIV    = 8'h04;
    localparam logic [7:0] OFS_TIMA   = 8'h05;
    localparam logic [7:0] OFS_TMA    = 8'h06;
    localparam logic [7:0] OFS_TAC    = 8'h07;
    localparam logic [7:0] OFS_IF     = 8'h0F;
    localparam logic [7:0] OFS_IE     = 8'hFF;

    // bits that always read as one
    localparam logic [7:0] ONES_JOYPAD = 8'b1100_0000;
    localparam logic [7:0] ONES_IF     = 8'b1110_0000;
    localparam logic [7:0] ONES_TAC    = 8'b1111_1000;
    localparam logic [7:0] ONES_SC     = 8'b0111_1110;

    localparam int TMR_IRQ_POS = 2;

    // TAC clock select
    localparam logic [1:0] TAC_P256 = 2'd0;
    localparam logic [1:0] TAC_P4   = 2'd1;
    localparam logic [1:0] TAC_P16  = 2'd2;
    localparam logic [1:0] TAC_P64  = 2'd3;

    // one word in execution
    typedef struct packed {
        logic       fire;
        t_req_type  req;
        logic [7:0] ofs;
        logic [7:0] data;
        logic       backdoor;
    } t_exec;

    // timer register view
    typedef struct packed {
        logic [7:0] div;
        logic [7:0] tima;
        logic [7:0] tma;
        logic [2:0] tac;
        logic       flag;
    } t_tmr_view;

    // interrupt controller result and view
    typedef struct packed {
        logic       taken;
        logic [6:0] vector;
        logic       wake;
        logic [4:0] if_bits;
        logic [7:0] ie;
    } t_irq_view;

    function automatic logic [6:0] irq_vec(input logic [2:0] idx);
        logic [6:0] v;
        unique case (idx)
            3'd0:    v = 7'h40;
            3'd1:    v = 7'h48;
            3'd2:    v = 7'h50;
            3'd3:    v = 7'h58;
            3'd4:    v = 7'h60;
            default: v = 7'h00;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/hti_ram.sv
module hti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/hti_timer.sv
module hti_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hti_pkg::t_exec     i_exec,
    output hti_pkg::t_tmr_view o_view
);

    logic [hti_pkg::CNT_W-1:0] r_counter, n_counter;
    logic [7:0]                r_tima, n_tima;
    logic [7:0]                r_tma, n_tma;
    logic [2:0]                r_tac, n_tac;
    logic                      hit;
    logic                      flag;
    logic                      is_tick;
    logic                      is_wr;

    assign is_tick = i_exec.fire && (i_exec.req == hti_pkg::REQ_TICK);
    assign is_wr   = i_exec.fire && (i_exec.req == hti_pkg::REQ_WRITE);

    always_comb begin
        n_counter = r_counter;
        n_tima    = r_tima;
        n_tma     = r_tma;
        n_tac     = r_tac;
        hit       = 1'b0;
        flag      = 1'b0;
        if (is_tick) begin
            n_counter = r_counter + 14'd1;
            // period hit: low counter bits all zero
            unique case (r_tac[1:0])
                hti_pkg::TAC_P256: hit = (n_counter[7:0] == 8'd0);
                hti_pkg::TAC_P4:   hit = (n_counter[1:0] == 2'd0);
                hti_pkg::TAC_P16:  hit = (n_counter[3:0] == 4'd0);
                hti_pkg::TAC_P64:  hit = (n_counter[5:0] == 6'd0);
                default:           hit = 1'b0;
            endcase
            if (r_tac[2] && hit) begin
                if (r_tima == 8'hFF) begin
                    n_tima = r_tma;
                    flag   = 1'b1;
                end else begin
                    n_tima = r_tima + 8'd1;
                end
            end
        end else if (is_wr) begin
            if (i_exec.ofs == hti_pkg::OFS_DIV) begin
                n_counter = '0;
            end else if (i_exec.ofs == hti_pkg::OFS_TIMA) begin
                n_tima = i_exec.data;
            end else if (i_exec.ofs == hti_pkg::OFS_TMA) begin
                n_tma = i_exec.data;
            end else if (i_exec.ofs == hti_pkg::OFS_TAC) begin
                n_tac = i_exec.data[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_tima    <= '0;
            r_tma     <= '0;
            r_tac     <= '0;
        end else begin
            r_counter <= n_counter;
            r_tima    <= n_tima;
            r_tma     <= n_tma;
            r_tac     <= n_tac;
        end
    end

    assign o_view.div  = r_counter[hti_pkg::CNT_W-1:hti_pkg::CNT_W-8];
    assign o_view.tima = r_tima;
    assign o_view.tma  = r_tma;
    assign o_view.tac  = r_tac;
    assign o_view.flag = flag;

endmodule

>>> hdl/hti_irq.sv
module hti_irq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hti_pkg::t_exec     i_exec,
    input  logic               i_timer_flag,
    input  logic               i_suppress,
    output hti_pkg::t_irq_view o_view
);

    logic [4:0] r_if, n_if;
    logic [7:0] r_ie, n_ie;
    logic       r_me, n_me;
    logic       r_st1, n_st1;
    logic       r_st2, n_st2;
    logic [4:0] pend;
    logic [2:0] idx;
    logic       take;

    assign pend = r_if & r_ie[4:0];

    // lowest pending source wins
    always_comb begin
        priority if (pend[0]) idx = 3'd0;
        else if (pend[1])     idx = 3'd1;
        else if (pend[2])     idx = 3'd2;
        else if (pend[3])     idx = 3'd3;
        else                  idx = 3'd4;
    end

    assign take = !i_suppress && r_me && (pend != 5'd0);

    always_comb begin
        n_if  = r_if;
        n_ie  = r_ie;
        n_me  = r_me;
        n_st1 = r_st1;
        n_st2 = r_st2;
        if (i_timer_flag) begin
            n_if[hti_pkg::TMR_IRQ_POS] = 1'b1;
        end
        if (i_exec.fire) begin
            unique case (i_exec.req)
                hti_pkg::REQ_WRITE: begin
                    if (i_exec.ofs == hti_pkg::OFS_IF) begin
                        n_if = i_exec.data[4:0];
                    end else if (i_exec.ofs == hti_pkg::OFS_IE) begin
                        n_ie = i_exec.data;
                    end
                end
                hti_pkg::REQ_STEP: begin
                    n_me  = r_st2;
                    n_st2 = r_st1;
                end
                hti_pkg::REQ_ME_ON:  n_st1 = 1'b1;
                hti_pkg::REQ_ME_OFF: n_me  = 1'b0;
                hti_pkg::REQ_CHECK: begin
                    if (take) begin
                        n_if[idx] = 1'b0;
                        n_me      = 1'b0;
                        n_st1     = 1'b0;
                        n_st2     = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if  <= '0;
            r_ie  <= '0;
            r_me  <= 1'b0;
            r_st1 <= 1'b0;
            r_st2 <= 1'b0;
        end else begin
            r_if  <= n_if;
            r_ie  <= n_ie;
            r_me  <= n_me;
            r_st1 <= n_st1;
            r_st2 <= n_st2;
        end
    end

    always_comb begin
        o_view.taken   = 1'b0;
        o_view.vector  = '0;
        o_view.wake    = 1'b0;
        o_view.if_bits = r_if;
        o_view.ie      = r_ie;
        if (i_exec.req == hti_pkg::REQ_CHECK) begin
            o_view.wake = (pend != 5'd0);
            if (take) begin
                o_view.taken  = 1'b1;
                o_view.vector = hti_pkg::irq_vec(idx);
            end
        end
    end

endmodule

>>> hdl/handheld_timer_interrupt_io_top.sv
// I/O register page (offsets 0x00-0xFF of 0xFF00-0xFFFF) with a DIV/TIMA/TMA/TAC
// timer and a five-source interrupt controller. Every request word (read, write,
// tick, step end, master enable/disable, interrupt check) yields exactly one
// result word. One word is accepted per clock while o_in_stall is low; a result
// passes through the execute register, then the output register, matching the registered
// read port of the page RAM. The joypad, DIV, TIMA, TMA, TAC, IF and IE registers
// live in flops; all other entries are in a 256x8 RAM with one valid flop per
// entry, so the page reads as zero after reset with no clearing pass. The config
// register (interrupt suppress) must be written only while the block is idle.
module handheld_timer_interrupt_io_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_reg_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_backdoor,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_irq_taken,
    output logic [6:0]  o_irq_vector,
    output logic        o_wake,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    logic                     accept;
    logic                     out_load;
    logic                     s1_adv;
    logic [hti_pkg::PAGE_AW-1:0] in_ofs;

    // execute stage
    logic                     r_s1_valid;
    hti_pkg::t_req_type       r_s1_req;
    logic [7:0]               r_s1_ofs;
    logic [7:0]               r_s1_data;
    logic                     r_s1_backdoor;
    logic                     r_s1_pvalid;   // page entry was written

    // output stage
    logic                     r_out_valid;
    logic [7:0]               r_rd_data, n_rd_data;
    logic                     r_taken;
    logic [6:0]               r_vector;
    logic                     r_wake;

    logic [hti_pkg::PAGE_DEPTH-1:0] r_page_valid;
    logic [7:0]               ram_q;
    logic [7:0]               page_byte;
    logic [5:0]               r_joy;
    logic                     r_suppress;

    hti_pkg::t_exec           exec;
    hti_pkg::t_tmr_view       tmr;
    hti_pkg::t_irq_view       irq;

    // handshake: execute stage moves whenever the output register can load
    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_load;
    assign o_in_stall = r_s1_valid && !out_load;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_ofs     = i_reg_address[hti_pkg::PAGE_AW-1:0];

    assign o_cfg_ready = 1'b1;

    // page RAM: written and read at acceptance, so order is kept word by word
    hti_ram #(
        .WIDTH (8),
        .DEPTH (hti_pkg::PAGE_DEPTH)
    ) u_page (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_req_type == hti_pkg::REQ_WRITE)),
        .i_wr_addr (in_ofs),
        .i_wr_data (i_write_data),
        .i_rd_en   (accept),
        .i_rd_addr (in_ofs),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_valid <= '0;
        end else if (accept && (i_req_type == hti_pkg::REQ_WRITE)) begin
            r_page_valid[in_ofs] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req      <= hti_pkg::t_req_type'(i_req_type);
            r_s1_ofs      <= in_ofs;
            r_s1_data     <= i_write_data;
            r_s1_backdoor <= i_backdoor;
            r_s1_pvalid   <= r_page_valid[in_ofs];
        end
    end

    assign exec.fire     = s1_adv;
    assign exec.req      = r_s1_req;
    assign exec.ofs      = r_s1_ofs;
    assign exec.data     = r_s1_data;
    assign exec.backdoor = r_s1_backdoor;

    hti_timer u_timer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_exec (exec),
        .o_view (tmr)
    );

    hti_irq u_irq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_exec      (exec),
        .i_timer_flag(tmr.flag),
        .i_suppress  (r_suppress),
        .o_view      (irq)
    );

    // joypad: low nibble is read-only unless written through the backdoor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joy <= '0;
        end else if (s1_adv && (r_s1_req == hti_pkg::REQ_WRITE)
                     && (r_s1_ofs == hti_pkg::OFS_JOYPAD)) begin
            if (r_s1_backdoor) begin
                r_joy <= r_s1_data[5:0];
            end else begin
                r_joy <= {r_s1_data[5:4], r_joy[3:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppress <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_suppress <= i_cfg_data;
        end
    end

    // read mux: flop-backed registers override the RAM copy
    assign page_byte = r_s1_pvalid ? ram_q : 8'h00;

    always_comb begin
        n_rd_data = 8'h00;
        if (r_s1_req == hti_pkg::REQ_READ) begin
            priority if (r_s1_ofs == hti_pkg::OFS_JOYPAD) begin
                n_rd_data = hti_pkg::ONES_JOYPAD | {2'b00, r_joy};
            end else if (r_s1_ofs == hti_pkg::OFS_SC) begin
                n_rd_data = hti_pkg::ONES_SC | page_byte;
            end else if (r_s1_ofs == hti_pkg::OFS_DIV) begin
                n_rd_data = tmr.div;
            end else if (r_s1_ofs == hti_pkg::OFS_TIMA) begin
                n_rd_data = tmr.tima;
            end else if (r_s1_ofs == hti_pkg::OFS_TMA) begin
                n_rd_data = tmr.tma;
            end else if (r_s1_ofs == hti_pkg::OFS_TAC) begin
                n_rd_data = hti_pkg::ONES_TAC | {5'b00000, tmr.tac};
            end else if (r_s1_ofs == hti_pkg::OFS_IF) begin
                n_rd_data = hti_pkg::ONES_IF | {3'b000, irq.if_bits};
            end else if (r_s1_ofs == hti_pkg::OFS_IE) begin
                n_rd_data = irq.ie;
            end else begin
                n_rd_data = page_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_rd_data <= n_rd_data;
            r_taken   <= irq.taken;
            r_vector  <= irq.vector;
            r_wake    <= irq.wake;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_rd_data;
    assign o_irq_taken  = r_taken;
    assign o_irq_vector = r_vector;
    assign o_wake       = r_wake;

endmodule
